// File: hw/rtl/llr_pkg.sv
// shared constants, codes and types of the linked list ranker
package llr_pkg;

    localparam int NODES = 1024;
    localparam int IDX_W = $clog2(NODES);
    localparam int VAL_W = IDX_W + 1;
    localparam int REQ_W = 2;

    // rank value of a node not on the list, and the last table index
    localparam logic [VAL_W-1:0] UNRANKED = VAL_W'(NODES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // answer codes
    localparam logic ANS_RUN  = 1'b0;
    localparam logic ANS_READ = 1'b1;

    // one port of a table memory
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_port_t;

    // one answer transaction
    typedef struct packed {
        logic             answer_kind;
        logic [VAL_W-1:0] rank_value;
        logic [VAL_W-1:0] nodes_ranked;
        logic             cycle_error;
    } answer_t;

endpackage

// File: hw/rtl/llr_req_if.sv
// request channel: valid/ready handshake with request payload
interface llr_req_if;
    logic                      valid;
    logic                      ready;
    logic [llr_pkg::REQ_W-1:0] req_type;
    logic [llr_pkg::IDX_W-1:0] node_index;
    logic [llr_pkg::VAL_W-1:0] next_index;
    logic [llr_pkg::IDX_W-1:0] list_head;
    logic [llr_pkg::VAL_W-1:0] list_length;

    modport source (
        output valid, req_type, node_index, next_index, list_head, list_length,
        input  ready
    );
    modport sink (
        input  valid, req_type, node_index, next_index, list_head, list_length,
        output ready
    );
endinterface

// File: hw/rtl/llr_resp_if.sv
// answer channel: valid/ready handshake with answer payload
interface llr_resp_if;
    logic                      valid;
    logic                      ready;
    logic                      answer_kind;
    logic [llr_pkg::VAL_W-1:0] rank_value;
    logic [llr_pkg::VAL_W-1:0] nodes_ranked;
    logic                      cycle_error;

    modport source (
        output valid, answer_kind, rank_value, nodes_ranked, cycle_error,
        input  ready
    );
    modport sink (
        input  valid, answer_kind, rank_value, nodes_ranked, cycle_error,
        output ready
    );
endinterface

// File: hw/rtl/linked_list_ranker_top.sv
// top level of the linked list ranker: memories, sequencer, answer register
//
//  channel | dir | transaction payload
//  --------+-----+-----------------------------------------------------------
//  req     | in  | req_type, node_index, next_index, list_head, list_length
//  resp    | out | answer_kind, rank_value, nodes_ranked, cycle_error
//
// a write is done on acceptance; a read fetches the rank, then waits on the answer register
// a run first clears all NODES (1024) ranks, then walks the list, writing each node's rank
//   and reading its successor, then builds the answer
// reset clears control and the walk position and count; both tables are
//   undefined until written, a run overwrites every rank
// the answer register frees the sequencer: a new transaction is taken while
//   an answer waits; a finished answer waits in the sequencer if it is full
module linked_list_ranker_top (
    input  logic       clk,
    input  logic       rst_n,
    llr_req_if.sink    req,
    llr_resp_if.source resp
);

    llr_pkg::ram_port_t        succ_port;
    llr_pkg::ram_port_t        rank_port;
    logic [llr_pkg::VAL_W-1:0] succ_rdata;
    logic [llr_pkg::VAL_W-1:0] rank_rdata;

    logic                      ans_valid;
    llr_pkg::answer_t          ans;
    logic                      ans_ready;

    logic                      out_valid_reg;
    llr_pkg::answer_t          out_reg;

    // successor table, one entry per node
    llr_ram #(
        .WIDTH (llr_pkg::VAL_W),
        .DEPTH (llr_pkg::NODES)
    ) u_succ_ram (
        .clk   (clk),
        .we    (succ_port.we),
        .waddr (succ_port.waddr),
        .wdata (succ_port.wdata),
        .re    (succ_port.re),
        .raddr (succ_port.raddr),
        .rdata (succ_rdata)
    );

    // rank table, one entry per node
    llr_ram #(
        .WIDTH (llr_pkg::VAL_W),
        .DEPTH (llr_pkg::NODES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_port.we),
        .waddr (rank_port.waddr),
        .wdata (rank_port.wdata),
        .re    (rank_port.re),
        .raddr (rank_port.raddr),
        .rdata (rank_rdata)
    );

    llr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .succ_port  (succ_port),
        .succ_rdata (succ_rdata),
        .rank_port  (rank_port),
        .rank_rdata (rank_rdata),
        .ans_valid  (ans_valid),
        .ans        (ans),
        .ans_ready  (ans_ready)
    );

    // answer register is free when empty or being drained this cycle
    assign ans_ready = !out_valid_reg || resp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ans_ready)
        begin
            out_valid_reg <= ans_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (ans_ready && ans_valid)
        begin
            out_reg <= ans;
        end
    end

    assign resp.valid        = out_valid_reg;
    assign resp.answer_kind  = out_reg.answer_kind;
    assign resp.rank_value   = out_reg.rank_value;
    assign resp.nodes_ranked = out_reg.nodes_ranked;
    assign resp.cycle_error  = out_reg.cycle_error;

endmodule

// File: hw/rtl/llr_ram.sv
// generic simple dual port ram, one write and one registered read port
module llr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/llr_ctrl.sv
// sequencer: request decode, rank clear sweep, list walk and answer build
module llr_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    llr_req_if.sink                   req,
    output llr_pkg::ram_port_t        succ_port,
    input  logic [llr_pkg::VAL_W-1:0] succ_rdata,
    output llr_pkg::ram_port_t        rank_port,
    input  logic [llr_pkg::VAL_W-1:0] rank_rdata,
    output logic                      ans_valid,
    output llr_pkg::answer_t          ans,
    input  logic                      ans_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_WALK,
        S_FETCH,
        S_READ,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [llr_pkg::VAL_W-1:0] pos_reg, pos_next;
    logic [llr_pkg::VAL_W-1:0] count_reg, count_next;
    logic [llr_pkg::VAL_W-1:0] limit_reg, limit_next;
    logic [llr_pkg::IDX_W-1:0] clr_reg, clr_next;
    logic                      cycle_reg, cycle_next;
    logic                      accept;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        limit_next = limit_reg;
        clr_next   = clr_reg;
        cycle_next = cycle_reg;

        succ_port       = '0;
        succ_port.waddr = req.node_index;
        succ_port.wdata = req.next_index;
        succ_port.raddr = pos_reg[llr_pkg::IDX_W-1:0];

        rank_port       = '0;
        rank_port.waddr = clr_reg;
        rank_port.wdata = llr_pkg::UNRANKED;
        rank_port.raddr = req.node_index;

        ans_valid        = 1'b0;
        ans              = '0;
        ans.answer_kind  = llr_pkg::ANS_RUN;
        ans.nodes_ranked = count_reg;
        ans.cycle_error  = cycle_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        llr_pkg::REQ_WRITE:
                        begin
                            succ_port.we = 1'b1;
                        end
                        llr_pkg::REQ_RUN:
                        begin
                            limit_next = (req.list_length > llr_pkg::UNRANKED) ?
                                         llr_pkg::UNRANKED : req.list_length;
                            pos_next   = llr_pkg::VAL_W'(req.list_head);
                            count_next = '0;
                            clr_next   = '0;
                            cycle_next = 1'b0;
                            state_next = S_CLEAR;
                        end
                        llr_pkg::REQ_READ:
                        begin
                            rank_port.re = 1'b1;
                            state_next   = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                rank_port.we = 1'b1;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == llr_pkg::LAST_IDX)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // top bit set means the successor ran off the table
                if (pos_reg[llr_pkg::IDX_W])
                begin
                    state_next = S_DONE;
                end
                else if (count_reg >= limit_reg)
                begin
                    cycle_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rank_port.we    = 1'b1;
                    rank_port.waddr = pos_reg[llr_pkg::IDX_W-1:0];
                    rank_port.wdata = count_reg;
                    succ_port.re    = 1'b1;
                    count_next      = count_reg + 1'b1;
                    state_next      = S_FETCH;
                end
            end
            S_FETCH:
            begin
                pos_next   = succ_rdata;
                state_next = S_WALK;
            end
            S_READ:
            begin
                ans_valid        = 1'b1;
                ans.answer_kind  = llr_pkg::ANS_READ;
                ans.rank_value   = rank_rdata;
                ans.nodes_ranked = '0;
                ans.cycle_error  = 1'b0;
                if (ans_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                ans_valid = 1'b1;
                if (ans_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            count_reg <= '0;
            limit_reg <= '0;
            clr_reg   <= '0;
            cycle_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            limit_reg <= limit_next;
            clr_reg   <= clr_next;
            cycle_reg <= cycle_next;
        end
    end

endmodule
